>>> rtl/v2a_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-dimensional vector arithmetic unit.
// No dependencies; imported by every module of the unit.
package v2a_pkg;

    localparam int FIELD_W      = 32;
    localparam int OP_W         = 3;
    localparam int DEF_DATA_W   = 32;
    localparam int DEF_FRAC_W   = 16;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd1;
    localparam logic [OP_W-1:0] OP_SCALE  = 3'd2;
    localparam logic [OP_W-1:0] OP_LENGTH = 3'd3;
    localparam logic [OP_W-1:0] OP_NORM   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        t_status         status;
    } t_ctl;

endpackage

>>> rtl/v2a_front.sv
`timescale 1ns / 1ps
// Front end: two register stages for add, subtract, scale and the sum of squares.
// Depends on v2a_pkg.
module v2a_front import v2a_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_W,
    parameter int FRAC_BITS  = DEF_FRAC_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [OP_W-1:0]           i_op,
    input  logic [DATA_WIDTH-1:0]     i_ax,
    input  logic [DATA_WIDTH-1:0]     i_ay,
    input  logic [DATA_WIDTH-1:0]     i_bx,
    input  logic [DATA_WIDTH-1:0]     i_by,
    input  logic [DATA_WIDTH-1:0]     i_f,
    output t_ctl                      o_ctl,
    output logic [2*DATA_WIDTH-1:0]   o_rem,
    output logic [4*DATA_WIDTH+1:0]   o_pass
);
    localparam int W  = DATA_WIDTH;
    localparam int W2 = 2 * DATA_WIDTH;

    t_ctl                    r1_ctl;
    logic [W:0]              r1_sx, r1_sy;
    logic signed [W2-1:0]    r1_px, r1_py;
    logic [W2-1:0]           r1_qx, r1_qy;
    logic [W-1:0]            r1_mx, r1_my;
    logic                    r1_nx, r1_ny;

    logic [W-1:0]            n_mx, n_my;
    logic [W:0]              ex_a, ey_a, ex_b, ey_b;

    t_ctl                    r2_ctl;
    logic [W-1:0]            r2_rx, r2_ry, r2_mx, r2_my;
    logic                    r2_nx, r2_ny;
    logic [W2-1:0]           r2_rem;

    logic [W2-1:0]           n_magx, n_magy, n_shx, n_shy, n_vx, n_vy;
    logic                    n_okx_s, n_oky_s, n_okx_a, n_oky_a;
    logic [W-1:0]            n_rx, n_ry;
    logic                    n_sat;
    t_ctl                    n_ctl;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    always_comb begin
        n_mx = i_ax[W-1] ? (~i_ax + 1'b1) : i_ax;
        n_my = i_ay[W-1] ? (~i_ay + 1'b1) : i_ay;
        ex_a = {i_ax[W-1], i_ax};
        ey_a = {i_ay[W-1], i_ay};
        ex_b = {i_bx[W-1], i_bx};
        ey_b = {i_by[W-1], i_by};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl.valid <= i_valid;
        end
        if (i_en) begin
            r1_ctl.op     <= i_op;
            r1_ctl.status <= ST_OK;
            r1_sx <= (i_op == OP_SUB) ? (ex_a - ex_b) : (ex_a + ex_b);
            r1_sy <= (i_op == OP_SUB) ? (ey_a - ey_b) : (ey_a + ey_b);
            r1_px <= $signed(i_ax) * $signed(i_f);
            r1_py <= $signed(i_ay) * $signed(i_f);
            r1_qx <= n_mx * n_mx;
            r1_qy <= n_my * n_my;
            r1_mx <= n_mx;
            r1_my <= n_my;
            r1_nx <= i_ax[W-1];
            r1_ny <= i_ay[W-1];
        end
    end

    always_comb begin
        n_magx  = r1_px[W2-1] ? (~r1_px + 1'b1) : r1_px;
        n_magy  = r1_py[W2-1] ? (~r1_py + 1'b1) : r1_py;
        n_shx   = n_magx >> FRAC_BITS;
        n_shy   = n_magy >> FRAC_BITS;
        n_vx    = r1_px[W2-1] ? (~n_shx + 1'b1) : n_shx;
        n_vy    = r1_py[W2-1] ? (~n_shy + 1'b1) : n_shy;
        n_okx_s = (n_vx[W2-1:W-1] == '0) || (n_vx[W2-1:W-1] == '1);
        n_oky_s = (n_vy[W2-1:W-1] == '0) || (n_vy[W2-1:W-1] == '1);
        n_okx_a = (r1_sx[W] == r1_sx[W-1]);
        n_oky_a = (r1_sy[W] == r1_sy[W-1]);
        n_rx    = '0;
        n_ry    = '0;
        n_sat   = 1'b0;
        case (r1_ctl.op)
            OP_ADD, OP_SUB: begin
                n_rx  = n_okx_a ? r1_sx[W-1:0] : (r1_sx[W] ? MINV : MAXV);
                n_ry  = n_oky_a ? r1_sy[W-1:0] : (r1_sy[W] ? MINV : MAXV);
                n_sat = !n_okx_a || !n_oky_a;
            end
            OP_SCALE: begin
                n_rx  = n_okx_s ? n_vx[W-1:0] : (n_vx[W2-1] ? MINV : MAXV);
                n_ry  = n_oky_s ? n_vy[W-1:0] : (n_vy[W2-1] ? MINV : MAXV);
                n_sat = !n_okx_s || !n_oky_s;
            end
            default: begin
                n_rx  = '0;
                n_ry  = '0;
                n_sat = 1'b0;
            end
        endcase
        n_ctl        = r1_ctl;
        n_ctl.status = n_sat ? ST_SAT : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r2_ctl.valid <= r1_ctl.valid;
        end
        if (i_en) begin
            r2_ctl.op     <= n_ctl.op;
            r2_ctl.status <= n_ctl.status;
            r2_rx  <= n_rx;
            r2_ry  <= n_ry;
            r2_mx  <= r1_mx;
            r2_my  <= r1_my;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;
            r2_rem <= r1_qx + r1_qy;
        end
    end

    assign o_ctl  = r2_ctl;
    assign o_rem  = r2_rem;
    assign o_pass = {r2_nx, r2_ny, r2_mx, r2_my, r2_rx, r2_ry};

endmodule

>>> rtl/v2a_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit of the restoring integer square root; settles one root bit per cell.
// Depends on v2a_pkg.
module v2a_sqrt_cell import v2a_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_W,
    parameter int STEP       = 0,
    parameter int PASS_W     = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_ctl                      i_ctl,
    input  logic [2*DATA_WIDTH-1:0]   i_rem,
    input  logic [2*DATA_WIDTH-1:0]   i_root,
    input  logic [PASS_W-1:0]         i_pass,
    output t_ctl                      o_ctl,
    output logic [2*DATA_WIDTH-1:0]   o_rem,
    output logic [2*DATA_WIDTH-1:0]   o_root,
    output logic [PASS_W-1:0]         o_pass
);
    localparam int W2 = 2 * DATA_WIDTH;
    localparam logic [W2-1:0] BITV = {{(W2-1){1'b0}}, 1'b1} << (2 * STEP);

    t_ctl            r_ctl;
    logic [W2-1:0]   r_rem, r_root, n_rem, n_root, trial;
    logic [PASS_W-1:0] r_pass;

    always_comb begin
        trial = i_root + BITV;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = (i_root >> 1) + BITV;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.op     <= i_ctl.op;
            r_ctl.status <= i_ctl.status;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pass <= i_pass;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pass = r_pass;

endmodule

>>> rtl/v2a_div_cell.sv
`timescale 1ns / 1ps
// One quotient bit of the restoring divide for both components of normalize.
// Depends on v2a_pkg.
module v2a_div_cell import v2a_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_W,
    parameter int FRAC_BITS  = DEF_FRAC_W,
    parameter int STEP       = 0,
    parameter int PASS_W     = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  t_ctl                             i_ctl,
    input  logic [DATA_WIDTH-1:0]            i_len,
    input  logic [DATA_WIDTH+FRAC_BITS-1:0]  i_nx,
    input  logic [DATA_WIDTH+FRAC_BITS-1:0]  i_ny,
    input  logic [FRAC_BITS:0]               i_qx,
    input  logic [FRAC_BITS:0]               i_qy,
    input  logic [PASS_W-1:0]                i_pass,
    output t_ctl                             o_ctl,
    output logic [DATA_WIDTH-1:0]            o_len,
    output logic [DATA_WIDTH+FRAC_BITS-1:0]  o_nx,
    output logic [DATA_WIDTH+FRAC_BITS-1:0]  o_ny,
    output logic [FRAC_BITS:0]               o_qx,
    output logic [FRAC_BITS:0]               o_qy,
    output logic [PASS_W-1:0]                o_pass
);
    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam logic [FRAC_BITS:0] QBIT = {{FRAC_BITS{1'b0}}, 1'b1} << STEP;

    t_ctl                   r_ctl;
    logic [DATA_WIDTH-1:0]  r_len;
    logic [NW-1:0]          r_nx, r_ny, dl;
    logic [FRAC_BITS:0]     r_qx, r_qy;
    logic [PASS_W-1:0]      r_pass;

    assign dl = {{FRAC_BITS{1'b0}}, i_len} << STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.op     <= i_ctl.op;
            r_ctl.status <= i_ctl.status;
            r_len  <= i_len;
            r_pass <= i_pass;
            r_nx   <= (i_nx >= dl) ? (i_nx - dl) : i_nx;
            r_ny   <= (i_ny >= dl) ? (i_ny - dl) : i_ny;
            r_qx   <= (i_nx >= dl) ? (i_qx | QBIT) : i_qx;
            r_qy   <= (i_ny >= dl) ? (i_qy | QBIT) : i_qy;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_len  = r_len;
    assign o_nx   = r_nx;
    assign o_ny   = r_ny;
    assign o_qx   = r_qx;
    assign o_qy   = r_qy;
    assign o_pass = r_pass;

endmodule

>>> rtl/vector2d_alu_unit.sv
`timescale 1ns / 1ps
// Two-dimensional vector unit in signed fixed point: add, subtract, scale, length, normalize.
// Pipeline: two front stages, one square-root cell per root bit,
// one divide cell per quotient bit, and the output register.
// Throughput is one request per cycle; the whole chain holds while a result waits.
// Synchronous active-low reset clears every valid bit; data registers are not reset.
module vector2d_alu_unit import v2a_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_W,
    parameter int FRAC_BITS  = DEF_FRAC_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // a_x, a_y, b_x, b_y, factor
    input  logic [5*FIELD_W-1:0] i_s_tdata,
    // req_type
    input  logic [OP_W-1:0]      i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // res_x, res_y, res_len
    output logic [3*FIELD_W-1:0] o_m_tdata,
    // status
    output logic [1:0]           o_m_tuser
);
    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int W2   = 2 * W;
    localparam int NW   = W + F;
    localparam int SPW  = 4 * W + 2;
    localparam int DPW  = 2 * W + 2;
    localparam int EW   = W + F + 2;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic en;

    t_ctl            s_ctl  [0:W];
    logic [W2-1:0]   s_rem  [0:W];
    logic [W2-1:0]   s_root [0:W];
    logic [SPW-1:0]  s_pass [0:W];

    t_ctl            d_ctl  [0:F+1];
    logic [W-1:0]    d_len  [0:F+1];
    logic [NW-1:0]   d_nx   [0:F+1];
    logic [NW-1:0]   d_ny   [0:F+1];
    logic [F:0]      d_qx   [0:F+1];
    logic [F:0]      d_qy   [0:F+1];
    logic [DPW-1:0]  d_pass [0:F+1];

    logic            r_out_valid;
    logic [W-1:0]    r_res_x, r_res_y, r_res_len;
    t_status         r_status;

    logic [W-1:0]    n_res_x, n_res_y, n_res_len;
    t_status         n_status;
    logic [EW-1:0]   vx, vy;
    logic            okx, oky;
    t_ctl            fin_ctl;
    logic [DPW-1:0]  fin_pass;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    v2a_front #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser),
        .i_ax    (i_s_tdata[0*FIELD_W +: W]),
        .i_ay    (i_s_tdata[1*FIELD_W +: W]),
        .i_bx    (i_s_tdata[2*FIELD_W +: W]),
        .i_by    (i_s_tdata[3*FIELD_W +: W]),
        .i_f     (i_s_tdata[4*FIELD_W +: W]),
        .o_ctl   (s_ctl[0]),
        .o_rem   (s_rem[0]),
        .o_pass  (s_pass[0])
    );
    assign s_root[0] = '0;

    for (genvar gi = 0; gi < W; gi++) begin : g_sqrt
        v2a_sqrt_cell #(.DATA_WIDTH(W), .STEP(W - 1 - gi), .PASS_W(SPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[gi]),
            .i_rem   (s_rem[gi]),
            .i_root  (s_root[gi]),
            .i_pass  (s_pass[gi]),
            .o_ctl   (s_ctl[gi+1]),
            .o_rem   (s_rem[gi+1]),
            .o_root  (s_root[gi+1]),
            .o_pass  (s_pass[gi+1])
        );
    end

    assign d_ctl[0]  = s_ctl[W];
    assign d_len[0]  = s_root[W][W-1:0];
    assign d_nx[0]   = {s_pass[W][4*W-1:3*W], {F{1'b0}}};
    assign d_ny[0]   = {s_pass[W][3*W-1:2*W], {F{1'b0}}};
    assign d_qx[0]   = '0;
    assign d_qy[0]   = '0;
    assign d_pass[0] = {s_pass[W][SPW-1:SPW-2], s_pass[W][2*W-1:0]};

    for (genvar gj = 0; gj <= F; gj++) begin : g_div
        v2a_div_cell #(.DATA_WIDTH(W), .FRAC_BITS(F), .STEP(F - gj), .PASS_W(DPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (d_ctl[gj]),
            .i_len   (d_len[gj]),
            .i_nx    (d_nx[gj]),
            .i_ny    (d_ny[gj]),
            .i_qx    (d_qx[gj]),
            .i_qy    (d_qy[gj]),
            .i_pass  (d_pass[gj]),
            .o_ctl   (d_ctl[gj+1]),
            .o_len   (d_len[gj+1]),
            .o_nx    (d_nx[gj+1]),
            .o_ny    (d_ny[gj+1]),
            .o_qx    (d_qx[gj+1]),
            .o_qy    (d_qy[gj+1]),
            .o_pass  (d_pass[gj+1])
        );
    end

    assign fin_ctl  = d_ctl[F+1];
    assign fin_pass = d_pass[F+1];

    always_comb begin
        vx  = fin_pass[DPW-1] ? (~{{(W+1){1'b0}}, d_qx[F+1]} + 1'b1)
                              : {{(W+1){1'b0}}, d_qx[F+1]};
        vy  = fin_pass[DPW-2] ? (~{{(W+1){1'b0}}, d_qy[F+1]} + 1'b1)
                              : {{(W+1){1'b0}}, d_qy[F+1]};
        okx = (vx[EW-1:W-1] == '0) || (vx[EW-1:W-1] == '1);
        oky = (vy[EW-1:W-1] == '0) || (vy[EW-1:W-1] == '1);
        n_res_x   = '0;
        n_res_y   = '0;
        n_res_len = '0;
        n_status  = ST_OK;
        case (fin_ctl.op)
            OP_ADD, OP_SUB, OP_SCALE: begin
                n_res_x  = fin_pass[2*W-1:W];
                n_res_y  = fin_pass[W-1:0];
                n_status = fin_ctl.status;
            end
            OP_LENGTH: begin
                n_res_len = d_len[F+1];
            end
            OP_NORM: begin
                if (d_len[F+1] == '0) begin
                    n_status = ST_ZERO;
                end else begin
                    n_res_len = d_len[F+1];
                    n_res_x   = okx ? vx[W-1:0] : (vx[EW-1] ? MINV : MAXV);
                    n_res_y   = oky ? vy[W-1:0] : (vy[EW-1] ? MINV : MAXV);
                    n_status  = (okx && oky) ? ST_OK : ST_SAT;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_x   <= n_res_x;
            r_res_y   <= n_res_y;
            r_res_len <= n_res_len;
            r_status  <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {FIELD_W'(r_res_len),
                         FIELD_W'($signed(r_res_y)),
                         FIELD_W'($signed(r_res_x))};
    assign o_m_tuser  = r_status;

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_ZERO) |-> (o_m_tdata == '0))
        else $error("zero-length result carries nonzero data");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while output drains");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_len_only_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_SAT) && (o_m_tdata[3*FIELD_W-1:2*FIELD_W] != '0)
        |-> (o_m_tdata[2*FIELD_W-1:0] != '0))
        else $error("saturated normalize with zero components");

endmodule

>>> dv/vector2d_alu_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for vector2d_alu_unit: random and directed vector requests
// are checked against a behavioral model of the fixed-point operations. Uses v2a_pkg.
module vector2d_alu_unit_tb;
    import v2a_pkg::*;

    localparam int DW = DEF_DATA_W;
    localparam int FW = DEF_FRAC_W;
    localparam int LATENCY = DW + FW + 4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [31:0] ax, ay, bx, by, factor;
    } t_vreq;

    typedef struct packed {
        logic [31:0] rx, ry, len;
        logic [1:0]  status;
    } t_vres;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [5*FIELD_W-1:0] s_data = '0;
    logic [OP_W-1:0] s_user = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3*FIELD_W-1:0] m_data;
    logic [1:0] m_user;

    t_vreq pending_reqs[$];
    t_vres expected_results[$];
    int errors = 0;
    bit stim_done = 1'b0;
    bit quiet = 1'b0;
    bit s_taken = 1'b0;
    int s_gap = 0;
    int m_stall = 0;

    vector2d_alu_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready),
        .i_s_tdata(s_data), .i_s_tuser(s_user),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready),
        .o_m_tdata(m_data), .o_m_tuser(m_user)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v,
                                                      inout bit sat);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] f);
        logic signed [63:0] p;
        logic [63:0] m;
        p = a * f;
        m = (p < 0) ? -p : p;
        m = m >> FW;
        return (p < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
                                                  input logic [63:0] len);
        logic [63:0] m;
        m = (a < 0) ? -a : a;
        m = (m << FW) / len;
        return (a < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_vres vector_result(input t_vreq q);
        t_vres r;
        logic signed [63:0] ax, ay, bx, by, f, rx, ry;
        logic [63:0] mx, my, len;
        bit sat;
        ax = $signed(q.ax);
        ay = $signed(q.ay);
        bx = $signed(q.bx);
        by = $signed(q.by);
        f = $signed(q.factor);
        rx = 0;
        ry = 0;
        len = 0;
        sat = 1'b0;
        r.status = ST_OK;
        case (q.op)
            OP_ADD: begin
                rx = clamp_word(ax + bx, sat);
                ry = clamp_word(ay + by, sat);
            end
            OP_SUB: begin
                rx = clamp_word(ax - bx, sat);
                ry = clamp_word(ay - by, sat);
            end
            OP_SCALE: begin
                rx = clamp_word(fx_mul(ax, f), sat);
                ry = clamp_word(fx_mul(ay, f), sat);
            end
            OP_LENGTH, OP_NORM: begin
                mx = (ax < 0) ? -ax : ax;
                my = (ay < 0) ? -ay : ay;
                len = root64(mx * mx + my * my);
                if (q.op == OP_NORM) begin
                    if (len == 0) begin
                        r.status = ST_ZERO;
                    end else begin
                        rx = clamp_word(fx_div(ax, len), sat);
                        ry = clamp_word(fx_div(ay, len), sat);
                    end
                end
            end
            default: ;
        endcase
        if (sat) r.status = ST_SAT;
        r.rx = rx[31:0];
        r.ry = ry[31:0];
        r.len = len[31:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(0, 2) << 16;
            4: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input logic [OP_W-1:0] op, input logic [31:0] ax, ay, bx, by, f);
        t_vreq q;
        q = '{op, ax, ay, bx, by, f};
        pending_reqs.push_back(q);
    endtask

    // Accepted requests are recorded at the edge where the handshake happens.
    always @(posedge i_clk) begin
        t_vreq acc;
        s_taken <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && s_valid && s_ready) begin
            acc = {s_user, s_data[31:0], s_data[63:32], s_data[95:64], s_data[127:96],
                   s_data[159:128]};
            expected_results.push_back(vector_result(acc));
        end
    end

    // Driver: a request stays presented until accepted.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_valid || s_taken) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    t_vreq q;
                    q = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_user <= q.op;
                    s_data <= {q.factor, q.by, q.bx, q.ay, q.ax};
                    if (!quiet && $urandom_range(0, 5) == 0) s_gap <= $urandom_range(1, 5);
                end else begin
                    s_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
            if (m_stall > 0) begin
                m_stall <= m_stall - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_stall <= $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            t_vres got, want;
            got = {m_data[31:0], m_data[63:32], m_data[95:64], m_user};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.rx !== want.rx)
                    $display("%0t: res_x expected %h actual %h", $time, want.rx, got.rx);
                if (got.ry !== want.ry)
                    $display("%0t: res_y expected %h actual %h", $time, want.ry, got.ry);
                if (got.len !== want.len)
                    $display("%0t: res_len expected %h actual %h", $time, want.len, got.len);
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                if (got !== want) errors++;
            end
        end
    end

    initial begin
        logic [OP_W-1:0] op;
        add_req(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 0);
        add_req(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0, 0);
        add_req(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 0);
        add_req(OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h8000_0000, 0);
        add_req(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF);
        add_req(OP_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 32'h0000_8000);
        add_req(OP_SCALE, 32'h8000_0000, 32'h0002_0000, 0, 0, 32'hFFFF_0000);
        add_req(OP_SCALE, 32'h0001_0000, 32'hFFFE_0000, 0, 0, 32'h8000_0000);
        add_req(OP_LENGTH, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        add_req(OP_LENGTH, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0);
        add_req(OP_LENGTH, 0, 0, 0, 0, 0);
        add_req(OP_NORM, 0, 0, 0, 0, 0);
        add_req(OP_NORM, 32'h0000_0001, 32'h0, 0, 0, 0);
        add_req(OP_NORM, 32'h0000_0001, 32'h0000_0001, 0, 0, 0);
        add_req(OP_NORM, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        add_req(OP_NORM, 32'hFFFD_0000, 32'h0004_0000, 0, 0, 0);
        add_req(3'd5, 32'h1234_5678, 32'h1, 32'h2, 32'h3, 32'h4);
        add_req(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
        add_req(3'd7, 0, 0, 0, 0, 0);
        for (int i = 0; i < 650; i++) begin
            op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(5, 7))
                                              : OP_W'($urandom_range(0, 4));
            add_req(op, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() < 100);
        quiet = 1'b1;
        wait (stim_done && expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
